>>> rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the tone sample block. Defining
// ASSERT_OFF turns every use into an empty statement.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define EST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define EST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define EST_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define EST_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/est_pkg.sv
// ============================================================================
// est_pkg
// Widths, constants, shared types and the sine magnitude table of the
// enveloped sine tone sample block.
// ============================================================================
package est_pkg;

    // Block constants. SINE_TABLE_DEPTH must be a power of two.
    localparam int PCM_RATE_HZ      = 16000;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int MS_PER_S         = 1000;
    localparam int MS_MAX           = 4095;

    // Field widths.
    localparam int F_W        = 14;
    localparam int MS_W       = 12;
    localparam int N_W        = 16;
    localparam int AMP_W      = 15;
    localparam int FADE_W     = 12;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(13107);
    localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(128);

    // Derived widths of the phase and length arithmetic.
    localparam int LOG2_DEPTH = $clog2(SINE_TABLE_DEPTH);
    localparam int SR_W       = $clog2(PCM_RATE_HZ + 1);
    localparam int P_W        = F_W + N_W;
    localparam int QP_W       = P_W - SR_W + 1;
    localparam int MP_W       = QP_W;
    localparam int RP0_W      = SR_W + 1;
    localparam int TX_W       = $clog2(MS_MAX * PCM_RATE_HZ + 1);
    localparam int MSD_W      = $clog2(MS_PER_S + 1);
    localparam int QT_W       = TX_W - (MSD_W - 1);
    localparam int RT_W       = $clog2(2 * MS_PER_S);
    localparam int TOTAL_W    = $clog2((MS_MAX * PCM_RATE_HZ) / MS_PER_S + 1);
    localparam int NT_W       = ((TOTAL_W > N_W) ? TOTAL_W : N_W) + 1;

    // Reciprocals for division by constants. The floor forms leave the
    // quotient at most one low, fixed up by one compare and subtract.
    localparam logic [63:0] MP = (64'd1 << P_W) / PCM_RATE_HZ;
    localparam logic [63:0] MT = (64'd1 << TX_W) / MS_PER_S;

    // Table index k = rem_phase * DEPTH / PCM_RATE_HZ, exact with a ceiling
    // reciprocal and a shift of KS.
    localparam int Y_W  = SR_W + LOG2_DEPTH;
    localparam int KS   = Y_W + SR_W;
    localparam int MK_W = Y_W + 2;
    localparam logic [63:0] MK = ((64'd1 << KS) + PCM_RATE_HZ - 1) / PCM_RATE_HZ;

    // Envelope and output scaling.
    localparam int ENV_FRAC_W  = 16;
    localparam int ENV_W       = ENV_FRAC_W + 1;
    localparam int SINE_MAG_W  = 15;
    localparam int MAG_ENV_W   = SINE_MAG_W + ENV_W;
    localparam int AMP_PROD_W  = MAG_ENV_W + AMP_W;
    localparam int PROD_SHIFT  = 31;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = ENV_FRAC_W / DIV_STEPS;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                 valid;
        logic [SR_W-1:0]      rem_phase;
        logic                 last;
        logic                 beyond;
        logic                 silent;
        logic                 env_full;
        logic [FADE_W-1:0]    env_num;
    } t_front;

    typedef logic [SINE_TABLE_DEPTH-1:0][SINE_MAG_W-1:0] t_sine_tab;

    // Unsigned quotient by shift and subtract, used only while the table
    // is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quot;
        logic [64:0] rem;
        quot = '0;
        rem  = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem     = rem - {1'b0, den};
                quot[b] = 1'b1;
            end
        end
        return quot;
    endfunction

    // Sine magnitude in Q15 for every table index, built at elaboration from
    // a Q2.30 Taylor series of the quarter wave.
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab                tab;
        logic [LOG2_DEPTH-1:0]    k;
        logic [63:0]              m;
        logic [63:0]              x;
        logic [63:0]              t;
        logic [63:0]              s;
        logic [63:0]              r;
        logic [63:0]              div;
        for (int idx = 0; idx < SINE_TABLE_DEPTH; idx++) begin
            k = LOG2_DEPTH'(idx);
            m = 64'({k[LOG2_DEPTH-3:0], 2'b00});
            if (k[LOG2_DEPTH-2]) begin
                m = 64'(SINE_TABLE_DEPTH) - m;
            end
            x = (m * HALF_PI_Q30) >> LOG2_DEPTH;
            t = x;
            s = x;
            for (int i = 1; i <= 7; i++) begin
                div = 64'((2 * i) * (2 * i + 1));
                t = udiv64(((((t * x) >> 30) * x) >> 30), div);
                if ((i % 2) == 1) begin
                    s = (s >= t) ? (s - t) : 64'd0;
                end else begin
                    s = s + t;
                end
            end
            r = (s + 64'd16384) >> 15;
            if (r > 64'd32767) begin
                r = 64'd32767;
            end
            tab[idx] = r[SINE_MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

>>> rtl/est_front.sv
// ============================================================================
// est_front
// Front stages: frequency-index product reduced modulo the sample rate,
// segment length in samples, end flags and the envelope numerator.
// ============================================================================
module est_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [est_pkg::F_W-1:0]    i_freq,
    input  logic [est_pkg::MS_W-1:0]   i_ms,
    input  logic [est_pkg::N_W-1:0]    i_n,
    input  logic [est_pkg::FADE_W-1:0] i_fade,
    output est_pkg::t_front            o_front
);
    import est_pkg::*;

    logic                r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [P_W-1:0]      r_s1_p, r_s2_p;
    logic [TX_W-1:0]     r_s1_tx, r_s2_tx;
    logic [N_W-1:0]      r_s1_n, r_s2_n, r_s3_n;
    logic                r_s1_silent, r_s2_silent, r_s3_silent;
    logic [QP_W-1:0]     r_s2_qp;
    logic [QT_W-1:0]     r_s2_qt, r_s3_qt;
    logic [RP0_W-1:0]    r_s3_rp0;
    logic [RT_W-1:0]     r_s3_rt0;
    t_front              r_front;

    logic [P_W-1:0]          n_p;
    logic [TX_W-1:0]         n_tx;
    logic [P_W+MP_W-1:0]     prod_p;
    logic [TX_W+QT_W-1:0]    prod_t;
    logic [QP_W+SR_W-1:0]    prod_qs;
    logic [QT_W+MSD_W-1:0]   prod_qm;
    logic [RP0_W-1:0]        n_rp0, rp_fix;
    logic [RT_W-1:0]         n_rt0;
    logic [QT_W:0]           total_sum;
    logic [NT_W-1:0]         tot_e, n_e, fade_e, remain;
    logic                    before_fade;
    logic                    in_tail;
    t_front                  n_front;

    // Stage 1: products.
    assign n_p  = P_W'(i_freq) * P_W'(i_n);
    assign n_tx = TX_W'(i_ms) * TX_W'(PCM_RATE_HZ);

    // Stage 2: quotient estimates through reciprocals.
    assign prod_p = (P_W+MP_W)'(r_s1_p) * (P_W+MP_W)'(MP);
    assign prod_t = (TX_W+QT_W)'(r_s1_tx) * (TX_W+QT_W)'(MT);

    // Stage 3: remainders, each below twice its divisor.
    assign prod_qs = (QP_W+SR_W)'(r_s2_qp) * (QP_W+SR_W)'(PCM_RATE_HZ);
    assign prod_qm = (QT_W+MSD_W)'(r_s2_qt) * (QT_W+MSD_W)'(MS_PER_S);
    assign n_rp0   = r_s2_p[RP0_W-1:0] - prod_qs[RP0_W-1:0];
    assign n_rt0   = r_s2_tx[RT_W-1:0] - prod_qm[RT_W-1:0];

    // Stage 4: final corrections, flags and envelope selection.
    always_comb begin
        rp_fix = (r_s3_rp0 >= RP0_W'(PCM_RATE_HZ)) ?
                 (r_s3_rp0 - RP0_W'(PCM_RATE_HZ)) : r_s3_rp0;
        total_sum = {1'b0, r_s3_qt} +
                    (QT_W+1)'(r_s3_rt0 >= RT_W'(MS_PER_S));
        tot_e  = NT_W'(total_sum[TOTAL_W-1:0]);
        n_e    = NT_W'(r_s3_n);
        fade_e = NT_W'(i_fade);
        remain = tot_e - n_e - NT_W'(1);
        before_fade = (n_e < fade_e);
        in_tail     = (remain < fade_e);

        n_front.valid     = r_s3_valid;
        n_front.rem_phase = rp_fix[SR_W-1:0];
        n_front.last      = (tot_e != '0) && (n_e == tot_e - NT_W'(1));
        n_front.beyond    = (n_e >= tot_e);
        n_front.silent    = r_s3_silent;
        n_front.env_full  = (i_fade == '0) || (!before_fade && !in_tail);
        n_front.env_num   = before_fade ? r_s3_n[FADE_W-1:0] : remain[FADE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_p      <= n_p;
        r_s1_tx     <= n_tx;
        r_s1_n      <= i_n;
        r_s1_silent <= (i_freq == '0);

        r_s2_p      <= r_s1_p;
        r_s2_tx     <= r_s1_tx;
        r_s2_qp     <= prod_p[P_W +: QP_W];
        r_s2_qt     <= prod_t[TX_W +: QT_W];
        r_s2_n      <= r_s1_n;
        r_s2_silent <= r_s1_silent;

        r_s3_rp0    <= n_rp0;
        r_s3_rt0    <= n_rt0;
        r_s3_qt     <= r_s2_qt;
        r_s3_n      <= r_s2_n;
        r_s3_silent <= r_s2_silent;

        r_front     <= n_front;
    end

    always_comb begin
        o_front       = r_front;
        o_front.valid = r_s4_valid;
    end

endmodule

>>> rtl/est_fade_div.sv
// ============================================================================
// est_fade_div
// Pipelined restoring divider for the fade envelope: numerator times 2^16
// over the fade length, four quotient bits per stage.
// ============================================================================
module est_fade_div (
    input  logic                           i_clk,
    input  logic [est_pkg::FADE_W-1:0]     i_num,
    input  logic [est_pkg::FADE_W-1:0]     i_fade,
    output logic [est_pkg::ENV_FRAC_W-1:0] o_quot
);
    import est_pkg::*;

    logic [FADE_W-1:0]     r_rem   [DIV_STAGES];
    logic [ENV_FRAC_W-1:0] r_quot  [DIV_STAGES];
    logic [FADE_W-1:0]     w_rem_in  [DIV_STAGES];
    logic [ENV_FRAC_W-1:0] w_quot_in [DIV_STAGES];
    logic [FADE_W-1:0]     n_rem   [DIV_STAGES];
    logic [ENV_FRAC_W-1:0] n_quot  [DIV_STAGES];

    assign w_rem_in[0]  = i_num;
    assign w_quot_in[0] = '0;

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
        assign w_rem_in[g]  = r_rem[g-1];
        assign w_quot_in[g] = r_quot[g-1];
    end

    // The numerator is below the fade length whenever the quotient is used, so
    // the partial remainder then stays below it and the doubled value fits one extra bit.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        always_comb begin
            logic [FADE_W:0]       trial;
            logic [FADE_W-1:0]     rem;
            logic [ENV_FRAC_W-1:0] quot;
            rem  = w_rem_in[g];
            quot = w_quot_in[g];
            for (int s = 0; s < DIV_STEPS; s++) begin
                trial = {rem, 1'b0};
                if (trial >= {1'b0, i_fade}) begin
                    trial = trial - {1'b0, i_fade};
                    quot  = {quot[ENV_FRAC_W-2:0], 1'b1};
                end else begin
                    quot  = {quot[ENV_FRAC_W-2:0], 1'b0};
                end
                rem = trial[FADE_W-1:0];
            end
            n_rem[g]  = rem;
            n_quot[g] = quot;
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem[g];
            r_quot[g] <= n_quot[g];
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule

>>> rtl/est_scale.sv
// ============================================================================
// est_scale
// Back stages: table index, sine lookup with quadrant sign, envelope and
// amplitude scaling, and the registered result.
// ============================================================================
module est_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  est_pkg::t_front                   i_front,
    input  logic [est_pkg::ENV_FRAC_W-1:0]    i_env_quot,
    input  logic [est_pkg::AMP_W-1:0]         i_amplitude,
    output logic                              o_valid,
    output logic signed [est_pkg::SAMPLE_W-1:0] o_sample,
    output logic                              o_last,
    output logic                              o_beyond
);
    import est_pkg::*;

    typedef struct packed {
        logic last;
        logic beyond;
        logic silent;
        logic env_full;
    } t_tag;

    localparam logic [ENV_W-1:0] ENV_ONE = {1'b1, {ENV_FRAC_W{1'b0}}};

    // One valid bit per stage, stage 5 at bit 0 through stage 10 at bit 5.
    logic [5:0]              r_vld;
    t_tag                    r_s5_tag, r_s6_tag, r_s7_tag, r_s8_tag, r_s9_tag;
    logic [LOG2_DEPTH-1:0]   r_s5_k;
    logic [SINE_MAG_W-1:0]   r_s6_mag, r_s7_mag, r_s8_mag;
    logic                    r_s6_neg, r_s7_neg, r_s8_neg, r_s9_neg;
    logic [MAG_ENV_W-1:0]    r_s9_prod;
    logic [SAMPLE_W-1:0]     r_sample;
    logic                    r_last, r_beyond;

    t_tag                    n_tag;
    logic [Y_W-1:0]          y;
    logic [Y_W+MK_W-1:0]     prod_k;
    logic [ENV_W-1:0]        n_env;
    logic [MAG_ENV_W-1:0]    n_prod;
    logic [AMP_PROD_W-1:0]   prod_amp;
    logic [SAMPLE_W-1:0]     mag_out;
    logic [SAMPLE_W-1:0]     n_sample;

    assign n_tag.last     = i_front.last;
    assign n_tag.beyond   = i_front.beyond;
    assign n_tag.silent   = i_front.silent;
    assign n_tag.env_full = i_front.env_full;

    assign y      = {i_front.rem_phase, {LOG2_DEPTH{1'b0}}};
    assign prod_k = (Y_W+MK_W)'(y) * (Y_W+MK_W)'(MK);

    // The divider output lines up with stage 8.
    assign n_env  = r_s8_tag.env_full ? ENV_ONE : {1'b0, i_env_quot};
    assign n_prod = MAG_ENV_W'(r_s8_mag) * MAG_ENV_W'(n_env);

    assign prod_amp = AMP_PROD_W'(r_s9_prod) * AMP_PROD_W'(i_amplitude);
    assign mag_out  = prod_amp[PROD_SHIFT +: SAMPLE_W];

    always_comb begin
        if (r_s9_tag.beyond || r_s9_tag.silent) begin
            n_sample = '0;
        end else if (r_s9_neg) begin
            n_sample = SAMPLE_W'(0) - mag_out;
        end else begin
            n_sample = mag_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_front.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_tag  <= n_tag;
        r_s5_k    <= prod_k[KS +: LOG2_DEPTH];

        r_s6_tag  <= r_s5_tag;
        r_s6_mag  <= SINE_TAB[r_s5_k];
        r_s6_neg  <= r_s5_k[LOG2_DEPTH-1];

        r_s7_tag  <= r_s6_tag;
        r_s7_mag  <= r_s6_mag;
        r_s7_neg  <= r_s6_neg;

        r_s8_tag  <= r_s7_tag;
        r_s8_mag  <= r_s7_mag;
        r_s8_neg  <= r_s7_neg;

        r_s9_tag  <= r_s8_tag;
        r_s9_neg  <= r_s8_neg;
        r_s9_prod <= n_prod;

        r_sample  <= n_sample;
        r_last    <= r_s9_tag.last;
        r_beyond  <= r_s9_tag.beyond;
    end

    assign o_valid  = r_vld[5];
    assign o_sample = r_sample;
    assign o_last   = r_last;
    assign o_beyond = r_beyond;

endmodule

>>> rtl/enveloped_sine_tone_sample.sv
// ============================================================================
// enveloped_sine_tone_sample
// Sine tone sample with linear fade envelope and amplitude scaling, built as
// a ten-stage pipeline with two configuration registers.
// ============================================================================
// Throughput: one transaction per cycle is accepted, busy stays low, and the
// receiver cannot stall the pipeline.
// The pipeline length is set by four front stages, the four divider stages of the
// fade envelope and two multiply stages for envelope and amplitude.
// Reset is synchronous: it clears every valid bit and reloads the amplitude
// and fade length; no memory needs a clearing pass.
`include "assert_macros.svh"

module enveloped_sine_tone_sample (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [est_pkg::F_W-1:0]             i_tone_freq_hz,
    input  logic [est_pkg::MS_W-1:0]            i_segment_ms,
    input  logic [est_pkg::N_W-1:0]             i_sample_number,
    input  logic                                i_cfg_we,
    input  logic [est_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [est_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [est_pkg::SAMPLE_W-1:0] o_sample_value,
    output logic                                o_last_sample,
    output logic                                o_beyond_end
);
    import est_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FADE      = CFG_IDX_W'(1);
    localparam int PIPE_LATENCY = 4 + DIV_STAGES + 2;

    logic [AMP_W-1:0]      r_amplitude;
    logic [FADE_W-1:0]     r_fade;
    logic                  in_valid;
    t_front                w_front;
    logic [ENV_FRAC_W-1:0] w_env_quot;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= AMP_RESET;
            r_fade      <= FADE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AMPLITUDE: r_amplitude <= i_cfg_wdata[AMP_W-1:0];
                CFG_FADE:      r_fade      <= i_cfg_wdata[FADE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    est_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_freq  (i_tone_freq_hz),
        .i_ms    (i_segment_ms),
        .i_n     (i_sample_number),
        .i_fade  (r_fade),
        .o_front (w_front)
    );

    est_fade_div u_fade_div (
        .i_clk  (i_clk),
        .i_num  (w_front.env_num),
        .i_fade (r_fade),
        .o_quot (w_env_quot)
    );

    est_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_front     (w_front),
        .i_env_quot  (w_env_quot),
        .i_amplitude (r_amplitude),
        .o_valid     (o_valid),
        .o_sample    (o_sample_value),
        .o_last      (o_last_sample),
        .o_beyond    (o_beyond_end)
    );

    // A result strobe only follows an accepted transaction at fixed latency.
    `EST_ASSERT_IMPLY(a_result_has_source, i_clk, i_rst_n, o_valid, $past(start, PIPE_LATENCY))
    `EST_ASSERT_NEVER(a_flags_exclusive, i_clk, i_rst_n, o_valid && o_last_sample && o_beyond_end)
    `EST_ASSERT_IMPLY(a_beyond_is_silent, i_clk, i_rst_n, o_valid && o_beyond_end, o_sample_value == '0)
    `EST_ASSERT_NEVER(a_mag_limit, i_clk, i_rst_n, o_valid && (o_sample_value == 16'sh8000 || o_sample_value == 16'sh7FFF))

endmodule
